[rtl/pvt_pkg.sv]
// ----------------------------------------------------------------------------
// pvt_pkg: shared types and constants of the point view transform
// Holds the coordinate widths, the queued point type, the register indexes
// and the quarter-wave sine table in Q1.15.
// ----------------------------------------------------------------------------
package pvt_pkg;

  // A point minus the camera origin is exact in 33 bits.
  localparam int DIFF_W  = 33;
  // Rotated coordinates stay below 37 bits.
  localparam int COORD_W = 37;
  // Quotient bits produced by the depth divider.
  localparam int QUOT_W  = 32;
  // Width of the screen coordinates.
  localparam int OUT_W   = 32;
  // Width of the configuration index and data.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ANGLE_W    = 9;
  localparam int FOCAL_W    = 16;
  localparam int QSINE_W    = 16;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } point_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_ANGLE_X     = 3'd3,
    REG_ANGLE_Y     = 3'd4,
    REG_ANGLE_Z     = 3'd5,
    REG_FOCAL       = 3'd6
  } cfg_reg_t;

  localparam logic [QSINE_W-1:0] QSINE [0:90] = '{
    16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
    16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
    16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384,
    16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795,
    16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926,
    16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
    16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166,
    16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
    16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792,
    16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928,
    16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
    16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // Indexes above the last entry read the last entry.
  function automatic logic [QSINE_W-1:0] quarter_sine(input logic [6:0] idx);
    logic [6:0] k;
    begin
      k = (idx > 7'd90) ? 7'd90 : idx;
      return QSINE[k];
    end
  endfunction

endpackage

[rtl/pvt_front.sv]
// ----------------------------------------------------------------------------
// pvt_front: input side of the point view transform
// Accepts points, subtracts the camera origin and holds the results in a
// short queue that the back end drains.
// ----------------------------------------------------------------------------
module pvt_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     point_x,
  input  logic signed [31:0]     point_y,
  input  logic signed [31:0]     point_z,
  input  logic signed [31:0]     origin_x,
  input  logic signed [31:0]     origin_y,
  input  logic signed [31:0]     origin_z,
  input  logic                   pop,
  output logic                   q_valid,
  output pvt_pkg::point_t        q_point
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  pvt_pkg::point_t mem [DEPTH];
  pvt_pkg::point_t diff;
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;
  logic [AW:0]     count_next;
  logic            push;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_point  = mem[rptr];

  assign diff.x = pvt_pkg::DIFF_W'(point_x) - pvt_pkg::DIFF_W'(origin_x);
  assign diff.y = pvt_pkg::DIFF_W'(point_y) - pvt_pkg::DIFF_W'(origin_y);
  assign diff.z = pvt_pkg::DIFF_W'(point_z) - pvt_pkg::DIFF_W'(origin_z);

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= diff;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue fill count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wptr - rptr) == count[AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/pvt_rot_stage.sv]
// ----------------------------------------------------------------------------
// pvt_rot_stage: one plane rotation
// Forms u = a*c - b*s and v = a*s + b*c over two stages, rounding half up
// by the sine fraction bits, and carries a third coordinate alongside.
// ----------------------------------------------------------------------------
module pvt_rot_stage #(
  parameter int SINE_FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [pvt_pkg::COORD_W-1:0]  a,
  input  logic signed [pvt_pkg::COORD_W-1:0]  b,
  input  logic signed [pvt_pkg::COORD_W-1:0]  t,
  input  logic signed [SINE_FRAC_BITS+1:0]    s,
  input  logic signed [SINE_FRAC_BITS+1:0]    c,
  output logic                                out_valid,
  output logic signed [pvt_pkg::COORD_W-1:0]  u,
  output logic signed [pvt_pkg::COORD_W-1:0]  v,
  output logic signed [pvt_pkg::COORD_W-1:0]  t_out
);

  localparam int CW = pvt_pkg::COORD_W;
  localparam int SW = SINE_FRAC_BITS + 2;
  localparam int PW = CW + SW;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) << (SINE_FRAC_BITS - 1);

  logic signed [PW-1:0] ac;
  logic signed [PW-1:0] bs;
  logic signed [PW-1:0] as_p;
  logic signed [PW-1:0] bc;
  logic signed [CW-1:0] t_a;
  logic                 v_a;
  logic signed [PW:0]   su;
  logic signed [PW:0]   sv;
  logic signed [PW:0]   su_sh;
  logic signed [PW:0]   sv_sh;

  assign su    = (PW+1)'(ac) - (PW+1)'(bs) + HALF;
  assign sv    = (PW+1)'(as_p) + (PW+1)'(bc) + HALF;
  assign su_sh = su >>> SINE_FRAC_BITS;
  assign sv_sh = sv >>> SINE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a       <= in_valid;
      out_valid <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac    <= a * c;
      bs    <= b * s;
      as_p  <= a * s;
      bc    <= b * c;
      t_a   <= t;
      u     <= su_sh[CW-1:0];
      v     <= sv_sh[CW-1:0];
      t_out <= t_a;
    end
  end

endmodule

[rtl/pvt_div_lane.sv]
// ----------------------------------------------------------------------------
// pvt_div_lane: pipelined restoring divider
// One quotient bit per stage; the partial remainder enters already below
// the divisor, so every stage is one narrow compare and subtract.
// ----------------------------------------------------------------------------
module pvt_div_lane #(
  parameter int DIV_W = 37,
  parameter int TAG_W = 36
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [DIV_W:0]              in_rem,
  input  logic [pvt_pkg::QUOT_W-1:0]  in_low,
  input  logic [DIV_W-1:0]            in_div,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [pvt_pkg::QUOT_W-1:0]  out_quot,
  output logic [TAG_W-1:0]            out_tag
);

  localparam int NS = pvt_pkg::QUOT_W;

  logic             v_r     [NS];
  logic [DIV_W:0]   rem_r   [NS];
  logic [NS-1:0]    low_r   [NS];
  logic [NS-1:0]    quot_r  [NS];
  logic [DIV_W-1:0] div_r   [NS];
  logic [TAG_W-1:0] tag_r   [NS];

  // Inputs seen by each stage: the lane inputs for the first, the previous
  // stage's registers for the rest.
  logic [DIV_W:0]   rem_in  [NS];
  logic [NS-1:0]    low_in  [NS];
  logic [NS-1:0]    quot_in [NS];
  logic [DIV_W-1:0] div_in  [NS];
  logic [TAG_W-1:0] tag_in  [NS];
  logic [DIV_W:0]   trial   [NS];
  logic             take    [NS];

  always_comb begin
    rem_in[0]  = in_rem;
    low_in[0]  = in_low;
    quot_in[0] = '0;
    div_in[0]  = in_div;
    tag_in[0]  = in_tag;
    for (int i = 1; i < NS; i++) begin
      rem_in[i]  = rem_r[i-1];
      low_in[i]  = low_r[i-1];
      quot_in[i] = quot_r[i-1];
      div_in[i]  = div_r[i-1];
      tag_in[i]  = tag_r[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      trial[i] = {rem_in[i][DIV_W-1:0], low_in[i][NS-1]};
      take[i]  = (trial[i] >= {1'b0, div_in[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        rem_r[i]  <= take[i] ? (trial[i] - {1'b0, div_in[i]}) : trial[i];
        low_r[i]  <= low_in[i] << 1;
        quot_r[i] <= {quot_in[i][NS-2:0], take[i]};
        div_r[i]  <= div_in[i];
        tag_r[i]  <= tag_in[i];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_quot  = quot_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

[rtl/pvt_back.sv]
// ----------------------------------------------------------------------------
// pvt_back: rotation and projection pipeline
// Three rotation stages, projection setup, two divider lanes and the output
// register, all advancing together whenever the output can move.
// ----------------------------------------------------------------------------
module pvt_back #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SINE_FRAC_BITS  = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  pvt_pkg::point_t                   q_point,
  output logic                              pop,
  input  logic [pvt_pkg::ANGLE_W-1:0]       angle_x_deg,
  input  logic [pvt_pkg::ANGLE_W-1:0]       angle_y_deg,
  input  logic [pvt_pkg::ANGLE_W-1:0]       angle_z_deg,
  input  logic [pvt_pkg::FOCAL_W-1:0]       focal_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                screen_x,
  output logic signed [31:0]                screen_y,
  output logic                              depth_zero,
  output logic                              overflow
);

  localparam int CW  = pvt_pkg::COORD_W;
  localparam int SW  = SINE_FRAC_BITS + 2;
  localparam int QW  = pvt_pkg::QUOT_W;
  localparam int OW  = pvt_pkg::OUT_W;
  localparam int PW  = CW + pvt_pkg::FOCAL_W + 1;
  localparam int NW  = PW + COORD_FRAC_BITS;
  localparam int UP  = (SINE_FRAC_BITS >= 15) ? SINE_FRAC_BITS - 15 : 0;
  localparam int DN  = (SINE_FRAC_BITS < 15) ? 15 - SINE_FRAC_BITS : 0;
  localparam int RND = (1 << DN) >> 1;
  localparam int TW  = pvt_pkg::QSINE_W + UP + 1;
  localparam logic signed [CW-1:0] SMAX = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0] SMIN = -SMAX - 1'b1;
  localparam logic [OW-1:0] OMAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] OMIN = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    logic          neg;
    logic          ovq;
    logic          dz;
    logic          ovd;
    logic [OW-1:0] sat;
  } lane_tag_t;

  localparam int TAG_W = $bits(lane_tag_t);

  function automatic logic signed [SW-1:0] sine_of(input logic [9:0] deg);
    logic [9:0]    a;
    logic [6:0]    idx;
    logic          neg;
    logic [TW-1:0] m;
    logic [SW-2:0] mag;
    begin
      a = (deg >= 10'd360) ? deg - 10'd360 : deg;
      priority if (a <= 10'd90) begin
        idx = a[6:0];
        neg = 1'b0;
      end else if (a <= 10'd180) begin
        idx = 7'(10'd180 - a);
        neg = 1'b0;
      end else if (a <= 10'd270) begin
        idx = 7'(a - 10'd180);
        neg = 1'b1;
      end else begin
        idx = 7'(10'd360 - a);
        neg = 1'b1;
      end
      m   = TW'(pvt_pkg::quarter_sine(idx)) << UP;
      m   = (m + TW'(RND)) >> DN;
      mag = m[SW-2:0];
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  endfunction

  function automatic logic [9:0] reduce(input logic [pvt_pkg::ANGLE_W-1:0] deg);
    logic [9:0] a;
    begin
      a = 10'(deg);
      return (a >= 10'd360) ? a - 10'd360 : a;
    end
  endfunction

  function automatic logic [OW:0] sat_coord(input logic signed [CW-1:0] val);
    begin
      priority if (val > SMAX) begin
        return {1'b1, OMAX};
      end else if (val < SMIN) begin
        return {1'b1, OMIN};
      end else begin
        return {1'b0, val[OW-1:0]};
      end
    end
  endfunction

  function automatic logic [OW:0] finish(input logic [QW-1:0] q, input lane_tag_t tg);
    begin
      priority if (tg.dz) begin
        return {tg.ovd, tg.sat};
      end else if (tg.ovq) begin
        return {1'b1, tg.neg ? OMIN : OMAX};
      end else if (!tg.neg) begin
        return q[QW-1] ? {1'b1, OMAX} : {1'b0, OW'(q)};
      end else begin
        return (q > QW'(OMIN)) ? {1'b1, OMIN} : {1'b0, OW'(-q)};
      end
    end
  endfunction

  // Whole pipeline moves when the output register is free or being taken.
  logic adv;
  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  // Sine and cosine terms, refreshed from the angle registers every cycle.
  logic signed [SW-1:0] sin_z, cos_z, nsin_y, cos_y, sin_x, cos_x;

  always_ff @(posedge clk) begin
    sin_z  <= sine_of(reduce(angle_z_deg));
    cos_z  <= sine_of(reduce(angle_z_deg) + 10'd90);
    nsin_y <= -sine_of(reduce(angle_y_deg));
    cos_y  <= sine_of(reduce(angle_y_deg) + 10'd90);
    sin_x  <= sine_of(reduce(angle_x_deg));
    cos_x  <= sine_of(reduce(angle_x_deg) + 10'd90);
  end

  logic                 v1, v2, v3;
  logic signed [CW-1:0] x1, y1, z0, x2, z1, y1d, y2, z2, x2d;

  pvt_rot_stage #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_rot_z (
    .clk(clk), .rst(rst), .en(adv), .in_valid(q_valid),
    .a(CW'(q_point.x)), .b(CW'(q_point.y)), .t(CW'(q_point.z)),
    .s(sin_z), .c(cos_z),
    .out_valid(v1), .u(x1), .v(y1), .t_out(z0)
  );

  // Negated sine turns the generic form into the rotation about y.
  pvt_rot_stage #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_rot_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v1),
    .a(x1), .b(z0), .t(y1),
    .s(nsin_y), .c(cos_y),
    .out_valid(v2), .u(x2), .v(z1), .t_out(y1d)
  );

  pvt_rot_stage #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_rot_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v2),
    .a(y1d), .b(z1), .t(x2),
    .s(sin_x), .c(cos_x),
    .out_valid(v3), .u(y2), .v(z2), .t_out(x2d)
  );

  // Projection setup: scale by focal length, take magnitudes, then test
  // for a quotient that cannot fit and split off the divider's start.
  logic                 p1_v, p2_v, p3_v;
  logic signed [PW-1:0] p1_nx, p1_ny;
  logic signed [CW-1:0] p1_z;
  lane_tag_t            p1_tx, p1_ty, p2_tx, p2_ty, p3_tx, p3_ty;
  logic [PW-1:0]        p2_mx, p2_my;
  logic [CW-1:0]        p2_d, p3_d;
  logic [NW-1:0]        nx_full, ny_full, nx_hi, ny_hi;
  logic [CW:0]          p3_rx, p3_ry;
  logic [QW-1:0]        p3_lx, p3_ly;
  logic [OW:0]          satx, saty;

  assign satx    = sat_coord(x2d);
  assign saty    = sat_coord(y2);
  assign nx_full = NW'(p2_mx) << COORD_FRAC_BITS;
  assign ny_full = NW'(p2_my) << COORD_FRAC_BITS;
  assign nx_hi   = nx_full >> QW;
  assign ny_hi   = ny_full >> QW;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else if (adv) begin
      p1_v <= v3;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_nx     <= x2d * $signed({1'b0, focal_length});
      p1_ny     <= y2 * $signed({1'b0, focal_length});
      p1_z      <= z2;
      p1_tx.dz  <= (z2 == '0);
      p1_tx.ovd <= satx[OW];
      p1_tx.sat <= satx[OW-1:0];
      p1_tx.neg <= 1'b0;
      p1_tx.ovq <= 1'b0;
      p1_ty.dz  <= (z2 == '0);
      p1_ty.ovd <= saty[OW];
      p1_ty.sat <= saty[OW-1:0];
      p1_ty.neg <= 1'b0;
      p1_ty.ovq <= 1'b0;

      p2_mx     <= p1_nx[PW-1] ? PW'(-p1_nx) : PW'(p1_nx);
      p2_my     <= p1_ny[PW-1] ? PW'(-p1_ny) : PW'(p1_ny);
      p2_d      <= p1_z[CW-1] ? CW'(-p1_z) : CW'(p1_z);
      // The sign of the quotient replaces the tag's top bit.
      p2_tx     <= {p1_nx[PW-1] != p1_z[CW-1], p1_tx[TAG_W-2:0]};
      p2_ty     <= {p1_ny[PW-1] != p1_z[CW-1], p1_ty[TAG_W-2:0]};

      p3_d      <= p2_d;
      p3_rx     <= nx_hi[CW:0];
      p3_ry     <= ny_hi[CW:0];
      p3_lx     <= nx_full[QW-1:0];
      p3_ly     <= ny_full[QW-1:0];
      p3_tx     <= {p2_tx.neg, nx_hi >= NW'(p2_d), p2_tx.dz, p2_tx.ovd, p2_tx.sat};
      p3_ty     <= {p2_ty.neg, ny_hi >= NW'(p2_d), p2_ty.dz, p2_ty.ovd, p2_ty.sat};
    end
  end

  logic          dx_v;
  logic [QW-1:0] qx, qy;
  lane_tag_t     tx, ty;

  pvt_div_lane #(.DIV_W(CW), .TAG_W(TAG_W)) u_div_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(p3_v),
    .in_rem(p3_rx), .in_low(p3_lx), .in_div(p3_d), .in_tag(p3_tx),
    .out_valid(dx_v), .out_quot(qx), .out_tag(tx)
  );

  pvt_div_lane #(.DIV_W(CW), .TAG_W(TAG_W)) u_div_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(p3_v),
    .in_rem(p3_ry), .in_low(p3_ly), .in_div(p3_d), .in_tag(p3_ty),
    .out_valid(), .out_quot(qy), .out_tag(ty)
  );

  logic [OW:0] fx, fy;
  assign fx = finish(qx, tx);
  assign fy = finish(qy, ty);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dx_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      screen_x   <= fx[OW-1:0];
      screen_y   <= fy[OW-1:0];
      depth_zero <= tx.dz;
      overflow   <= fx[OW] | fy[OW];
    end
  end

endmodule

[rtl/point_view_transform.sv]
// ----------------------------------------------------------------------------
// point_view_transform: camera view transform and perspective projection
// Moves each point into camera space, rotates it about z, y and x, and
// projects it onto the screen with saturation and a zero-depth bypass.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   input    in_valid / in_ready  point_x, point_y, point_z
//   output   out_valid/out_ready  screen_x, screen_y, depth_zero, overflow
//   config   cfg_we               cfg_index, cfg_data (write only)
//
// One point is accepted and one result delivered per clock when the output
// side keeps taking results. On its way to out_valid an accepted point
// leaves the queue and passes the six registers of the three rotations,
// three in projection setup, 32 in the divider pipeline (one quotient bit
// per stage) and the output register. A synchronous rst clears the queue,
// all valid flags and loads the register defaults. When the output stalls
// the whole back pipeline holds, and the four-entry queue keeps accepting
// transactions until full.
//
module point_view_transform #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SINE_FRAC_BITS  = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  point_x,
  input  logic signed [31:0]                  point_y,
  input  logic signed [31:0]                  point_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  screen_x,
  output logic signed [31:0]                  screen_y,
  output logic                                depth_zero,
  output logic                                overflow,
  input  logic                                cfg_we,
  input  logic [pvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pvt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers. Angles keep the low nine bits of the written
  // data; the back end folds values of 360 and above back by one turn.
  logic signed [31:0]               origin_x;
  logic signed [31:0]               origin_y;
  logic signed [31:0]               origin_z;
  logic [pvt_pkg::ANGLE_W-1:0]      angle_x_deg;
  logic [pvt_pkg::ANGLE_W-1:0]      angle_y_deg;
  logic [pvt_pkg::ANGLE_W-1:0]      angle_z_deg;
  logic [pvt_pkg::FOCAL_W-1:0]      focal_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= 32'sd131072;
      origin_y     <= 32'sd196608;
      origin_z     <= 32'sd327680;
      angle_x_deg  <= 9'd0;
      angle_y_deg  <= 9'd0;
      angle_z_deg  <= 9'd90;
      focal_length <= 16'd256;
    end else if (cfg_we) begin
      // Writes to an index past the last register are dropped.
      unique case (cfg_index)
        pvt_pkg::REG_ORIGIN_X: origin_x     <= $signed(cfg_data);
        pvt_pkg::REG_ORIGIN_Y: origin_y     <= $signed(cfg_data);
        pvt_pkg::REG_ORIGIN_Z: origin_z     <= $signed(cfg_data);
        pvt_pkg::REG_ANGLE_X:  angle_x_deg  <= cfg_data[pvt_pkg::ANGLE_W-1:0];
        pvt_pkg::REG_ANGLE_Y:  angle_y_deg  <= cfg_data[pvt_pkg::ANGLE_W-1:0];
        pvt_pkg::REG_ANGLE_Z:  angle_z_deg  <= cfg_data[pvt_pkg::ANGLE_W-1:0];
        pvt_pkg::REG_FOCAL:    focal_length <= cfg_data[pvt_pkg::FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: origin subtraction and the queue that decouples acceptance
  // from the back pipeline's stalls.
  logic            q_valid;
  logic            pop;
  pvt_pkg::point_t q_point;

  pvt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .pop(pop), .q_valid(q_valid), .q_point(q_point)
  );

  // Back end: rotations, projection and the output register.
  pvt_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_point(q_point), .pop(pop),
    .angle_x_deg(angle_x_deg), .angle_y_deg(angle_y_deg),
    .angle_z_deg(angle_z_deg), .focal_length(focal_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .screen_x(screen_x), .screen_y(screen_y),
    .depth_zero(depth_zero), .overflow(overflow)
  );

endmodule
